@@ sv/fbdc_pkg.sv @@
// fbdc_pkg: shared types and constants of the frame buffer writer
// no dependencies
`default_nettype none
package fbdc_pkg;

	localparam logic [1:0] OP_PIX565 = 2'd0;
	localparam logic [1:0] OP_PIX888 = 2'd1;
	localparam logic [1:0] OP_FLUSH  = 2'd2;
	localparam logic [1:0] OP_FADE   = 2'd3;

	localparam logic [1:0] REG_CLIP_LEFT   = 2'd0;
	localparam logic [1:0] REG_CLIP_TOP    = 2'd1;
	localparam logic [1:0] REG_CLIP_RIGHT  = 2'd2;
	localparam logic [1:0] REG_CLIP_BOTTOM = 2'd3;

	localparam logic [2:0] ST_WRITTEN     = 3'd0;
	localparam logic [2:0] ST_CLIPPED     = 3'd1;
	localparam logic [2:0] ST_TRANSPARENT = 3'd2;
	localparam logic [2:0] ST_UNCHANGED   = 3'd3;
	localparam logic [2:0] ST_TOO_DARK    = 3'd4;
	localparam logic [2:0] ST_FLUSH_RANGE = 3'd5;
	localparam logic [2:0] ST_FLUSH_EMPTY = 3'd6;
	localparam logic [2:0] ST_FADE_DONE   = 3'd7;

	localparam logic [7:0]  DARK_LIMIT = 8'd20;
	localparam logic [15:0] FADE_FLOOR = 16'h2108;
	localparam logic [6:0]  PCT_FULL   = 7'd100;
	// floor(n / 100) == (n * 5243) >> 19 for n < 6400
	localparam logic [12:0] RECIP_100  = 13'd5243;
	localparam int          RECIP_SH   = 19;

	localparam int IN_DATA_W  = 72;
	localparam int OUT_DATA_W = 16;

	typedef enum logic [1:0] {
		CMD_DROP,
		CMD_PIX,
		CMD_FLUSH,
		CMD_FADE
	} cmd_kind_t;

	typedef struct packed {
		cmd_kind_t  kind;
		logic [2:0] status;
		logic [7:0] col;
		logic [7:0] row;
		logic [15:0] value;
		logic [6:0] keep;
	} cmd_t;

	typedef struct packed {
		logic [7:0] left;
		logic [7:0] top;
		logic [7:0] right;
		logic [7:0] bottom;
	} clip_t;

endpackage
`default_nettype wire

@@ sv/fbdc_front.sv @@
// fbdc_front: clip registers and classification of incoming beats into commands
// depends on fbdc_pkg
`default_nettype none
module fbdc_front #(
	parameter int WIDTH  = 240,
	parameter int HEIGHT = 240
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           cfg_valid,
	input  wire logic [1:0]                     cfg_index,
	input  wire logic [7:0]                     cfg_data,
	input  wire logic [fbdc_pkg::IN_DATA_W-1:0] s_tdata,
	input  wire logic [1:0]                     s_tuser,
	output fbdc_pkg::cmd_t                      cmd,
	output fbdc_pkg::clip_t                     clip
);
	fbdc_pkg::clip_t clip_q;
	logic signed [11:0] pos_x, pos_y;
	logic [15:0] pixel_value;
	logic [7:0]  red, green, blue;
	logic [6:0]  fade_percent;
	logic [15:0] rgb565, value;
	logic        dark, clipped;
	logic signed [12:0] sx, sy;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clip_q.left   <= '0;
			clip_q.top    <= '0;
			clip_q.right  <= 8'(WIDTH);
			clip_q.bottom <= 8'(HEIGHT);
		end else if (cfg_valid) begin
			unique case (cfg_index)
				fbdc_pkg::REG_CLIP_LEFT: clip_q.left <= cfg_data;
				fbdc_pkg::REG_CLIP_TOP: clip_q.top <= cfg_data;
				fbdc_pkg::REG_CLIP_RIGHT:
					clip_q.right <= (9'(cfg_data) > 9'(WIDTH)) ? 8'(WIDTH) : cfg_data;
				default: clip_q.bottom <= (9'(cfg_data) > 9'(HEIGHT)) ? 8'(HEIGHT) : cfg_data;
			endcase
		end
	end

	assign clip = clip_q;

	assign pos_x        = s_tdata[11:0];
	assign pos_y        = s_tdata[23:12];
	assign pixel_value  = s_tdata[39:24];
	assign red          = s_tdata[47:40];
	assign green        = s_tdata[55:48];
	assign blue         = s_tdata[63:56];
	assign fade_percent = s_tdata[70:64];

	assign sx = 13'(pos_x);
	assign sy = 13'(pos_y);
	assign rgb565 = {red[7:3], green[7:2], blue[7:3]};
	assign dark = (red < fbdc_pkg::DARK_LIMIT) && (green < fbdc_pkg::DARK_LIMIT)
		&& (blue < fbdc_pkg::DARK_LIMIT);
	assign value = (s_tuser == fbdc_pkg::OP_PIX888) ? {rgb565[7:0], rgb565[15:8]} : pixel_value;
	assign clipped = (sx < $signed({5'b0, clip_q.left})) || (sy < $signed({5'b0, clip_q.top}))
		|| (sx >= $signed({5'b0, clip_q.right})) || (sy >= $signed({5'b0, clip_q.bottom}));

	always_comb begin
		cmd.kind   = fbdc_pkg::CMD_DROP;
		cmd.status = fbdc_pkg::ST_WRITTEN;
		cmd.col    = 8'(WIDTH - 1) - pos_x[7:0];
		cmd.row    = pos_y[7:0];
		cmd.value  = value;
		cmd.keep   = (fade_percent > fbdc_pkg::PCT_FULL) ? 7'd0 : fbdc_pkg::PCT_FULL - fade_percent;
		unique case (s_tuser) inside
			fbdc_pkg::OP_PIX565, fbdc_pkg::OP_PIX888: begin
				if (s_tuser == fbdc_pkg::OP_PIX888 && dark)
					cmd.status = fbdc_pkg::ST_TOO_DARK;
				else if (clipped)
					cmd.status = fbdc_pkg::ST_CLIPPED;
				else if (value == 16'd0)
					cmd.status = fbdc_pkg::ST_TRANSPARENT;
				else
					cmd.kind = fbdc_pkg::CMD_PIX;
			end
			fbdc_pkg::OP_FLUSH: cmd.kind = fbdc_pkg::CMD_FLUSH;
			default: begin
				cmd.status = fbdc_pkg::ST_FADE_DONE;
				if (fade_percent != 7'd0)
					cmd.kind = fbdc_pkg::CMD_FADE;
			end
		endcase
	end
endmodule
`default_nettype wire

@@ sv/fbdc_queue.sv @@
// fbdc_queue: two-entry command queue between front and back
// depends on fbdc_pkg
`default_nettype none
module fbdc_queue (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    push,
	input  fbdc_pkg::cmd_t push_cmd,
	output logic         full,
	input  wire logic    pop,
	output logic         not_empty,
	output fbdc_pkg::cmd_t head
);
	fbdc_pkg::cmd_t entry_q [2];
	logic wr_ptr_q, rd_ptr_q;
	logic [1:0] count_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= 1'b0;
			rd_ptr_q <= 1'b0;
			count_q  <= 2'd0;
		end else begin
			if (push)
				wr_ptr_q <= ~wr_ptr_q;
			if (pop)
				rd_ptr_q <= ~rd_ptr_q;
			count_q <= count_q + 2'(push) - 2'(pop);
		end
	end

	always_ff @(posedge clk) begin
		if (push)
			entry_q[wr_ptr_q] <= push_cmd;
	end

	assign full      = count_q == 2'd2;
	assign not_empty = count_q != 2'd0;
	assign head      = entry_q[rd_ptr_q];
endmodule
`default_nettype wire

@@ sv/fbdc_back.sv @@
// fbdc_back: frame store, dirty map and the sequencer for writes, flush and fade
// depends on fbdc_pkg
`default_nettype none
module fbdc_back #(
	parameter int WIDTH  = 240,
	parameter int HEIGHT = 240
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  wire logic    q_valid,
	input  fbdc_pkg::cmd_t q_cmd,
	output logic         q_pop,
	input  fbdc_pkg::clip_t clip,
	output logic         clearing,
	output logic         m_tvalid,
	input  wire logic    m_tready,
	output logic [fbdc_pkg::OUT_DATA_W-1:0] m_tdata,
	output logic [2:0]   m_tuser
);
	localparam int DEPTH = WIDTH * HEIGHT;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = $clog2(WIDTH);
	localparam int RECIP_SH_HI = fbdc_pkg::RECIP_SH + 5;

	typedef enum logic [3:0] {
		S_CLEAR, S_IDLE, S_PIX_RD, S_PIX_CMP, S_FL_WALK,
		S_FA_RD, S_FA_MUL1, S_FA_MUL2, S_FA_WR
	} state_t;

	state_t state_q;
	logic [15:0] mem [DEPTH];
	logic [15:0] rd_data;
	logic [AW-1:0] clr_addr_q, addr;
	logic [7:0]  col_q, row_q, x_q, start_q, end_q;
	logic [15:0] val_q, old_q;
	logic [6:0]  keep_q;
	logic        any_q;
	logic [WIDTH-1:0] dirty_q;
	logic [12:0] pr_q, pg_q, pb_q;
	logic [5:0]  qr_q, qg_q, qb_q;
	logic [15:0] px, fade_raw, fade_val;
	logic        we;
	logic [AW-1:0] waddr;
	logic [15:0] wdata;
	logic        out_valid_q;
	logic [2:0]  out_status_q;
	logic [7:0]  out_start_q, out_end_q;
	logic [25:0] mr, mg, mb;

	assign addr = AW'(32'(col_q) * HEIGHT + 32'(row_q));
	assign px = {rd_data[7:0], rd_data[15:8]};
	assign fade_raw = {qg_q[2:0], qb_q[4:0], qr_q[4:0], qg_q[5:3]};
	assign fade_val = (fade_raw == 16'd0) ? fbdc_pkg::FADE_FLOOR : fade_raw;
	assign mr = pr_q * fbdc_pkg::RECIP_100;
	assign mg = pg_q * fbdc_pkg::RECIP_100;
	assign mb = pb_q * fbdc_pkg::RECIP_100;

	always_comb begin
		we    = 1'b0;
		waddr = addr;
		wdata = val_q;
		unique case (state_q)
			S_CLEAR: begin
				we    = 1'b1;
				waddr = clr_addr_q;
				wdata = 16'd0;
			end
			S_PIX_CMP: we = rd_data != val_q;
			S_FA_WR: begin
				we    = fade_val != old_q;
				wdata = fade_val;
			end
			default: we = 1'b0;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		rd_data <= mem[addr];
	end

	assign q_pop    = (state_q == S_IDLE) && !out_valid_q && q_valid;
	assign clearing = state_q == S_CLEAR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_CLEAR;
			clr_addr_q   <= '0;
			dirty_q      <= '0;
			out_valid_q  <= 1'b0;
			out_status_q <= fbdc_pkg::ST_WRITTEN;
			out_start_q  <= '0;
			out_end_q    <= '0;
			col_q <= '0; row_q <= '0; x_q <= '0; val_q <= '0; old_q <= '0;
			keep_q <= '0; any_q <= 1'b0; start_q <= '0; end_q <= '0;
			pr_q <= '0; pg_q <= '0; pb_q <= '0; qr_q <= '0; qg_q <= '0; qb_q <= '0;
		end else begin
			if (out_valid_q && m_tready)
				out_valid_q <= 1'b0;
			unique case (state_q)
				S_CLEAR: begin
					clr_addr_q <= clr_addr_q + 1'b1;
					if (clr_addr_q == AW'(DEPTH - 1))
						state_q <= S_IDLE;
				end
				S_IDLE: begin
					if (q_pop) begin
						col_q  <= q_cmd.col;
						row_q  <= q_cmd.row;
						val_q  <= q_cmd.value;
						keep_q <= q_cmd.keep;
						unique case (q_cmd.kind)
							fbdc_pkg::CMD_DROP: begin
								out_valid_q  <= 1'b1;
								out_status_q <= q_cmd.status;
								out_start_q  <= '0;
								out_end_q    <= '0;
							end
							fbdc_pkg::CMD_PIX: state_q <= S_PIX_RD;
							fbdc_pkg::CMD_FLUSH: begin
								col_q   <= '0;
								any_q   <= 1'b0;
								start_q <= '0;
								end_q   <= '0;
								state_q <= S_FL_WALK;
							end
							default: begin
								if (clip.left >= clip.right || clip.top >= clip.bottom) begin
									out_valid_q  <= 1'b1;
									out_status_q <= fbdc_pkg::ST_FADE_DONE;
									out_start_q  <= '0;
									out_end_q    <= '0;
								end else begin
									x_q     <= clip.left;
									col_q   <= 8'(WIDTH - 1) - clip.left;
									row_q   <= clip.top;
									state_q <= S_FA_RD;
								end
							end
						endcase
					end
				end
				S_PIX_RD: state_q <= S_PIX_CMP;
				S_PIX_CMP: begin
					out_valid_q <= 1'b1;
					out_start_q <= '0;
					out_end_q   <= '0;
					if (rd_data == val_q) begin
						out_status_q <= fbdc_pkg::ST_UNCHANGED;
					end else begin
						out_status_q <= fbdc_pkg::ST_WRITTEN;
						dirty_q[col_q[CW-1:0]] <= 1'b1;
					end
					state_q <= S_IDLE;
				end
				S_FL_WALK: begin
					if (dirty_q[col_q[CW-1:0]]) begin
						dirty_q[col_q[CW-1:0]] <= 1'b0;
						if (!any_q)
							start_q <= col_q;
						any_q <= 1'b1;
						end_q <= col_q + 8'd1;
					end
					col_q <= col_q + 8'd1;
					if (col_q == 8'(WIDTH - 1)) begin
						out_valid_q <= 1'b1;
						if (any_q || dirty_q[col_q[CW-1:0]]) begin
							out_status_q <= fbdc_pkg::ST_FLUSH_RANGE;
							out_start_q  <= any_q ? start_q : col_q;
							out_end_q    <= dirty_q[col_q[CW-1:0]] ? col_q + 8'd1 : end_q;
						end else begin
							out_status_q <= fbdc_pkg::ST_FLUSH_EMPTY;
							out_start_q  <= '0;
							out_end_q    <= '0;
						end
						state_q <= S_IDLE;
					end
				end
				S_FA_RD: state_q <= S_FA_MUL1;
				S_FA_MUL1: begin
					old_q   <= rd_data;
					pr_q    <= 13'(px[15:11]) * 13'(keep_q);
					pg_q    <= 13'(px[10:5]) * 13'(keep_q);
					pb_q    <= 13'(px[4:0]) * 13'(keep_q);
					state_q <= S_FA_MUL2;
				end
				S_FA_MUL2: begin
					qr_q    <= mr[RECIP_SH_HI:fbdc_pkg::RECIP_SH];
					qg_q    <= mg[RECIP_SH_HI:fbdc_pkg::RECIP_SH];
					qb_q    <= mb[RECIP_SH_HI:fbdc_pkg::RECIP_SH];
					state_q <= S_FA_WR;
				end
				S_FA_WR: begin
					if (fade_val != old_q)
						dirty_q[col_q[CW-1:0]] <= 1'b1;
					if (9'(row_q) + 9'd1 < 9'(clip.bottom)) begin
						row_q   <= row_q + 8'd1;
						state_q <= S_FA_RD;
					end else if (9'(x_q) + 9'd1 < 9'(clip.right)) begin
						x_q     <= x_q + 8'd1;
						col_q   <= col_q - 8'd1;
						row_q   <= clip.top;
						state_q <= S_FA_RD;
					end else begin
						out_valid_q  <= 1'b1;
						out_status_q <= fbdc_pkg::ST_FADE_DONE;
						out_start_q  <= '0;
						out_end_q    <= '0;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tuser  = out_status_q;
	assign m_tdata  = {out_end_q, out_start_q};
endmodule
`default_nettype wire

@@ sv/framebuffer_writer_dirty_columns_top.sv @@
// framebuffer_writer_dirty_columns_top: frame buffer writer with dirty column tracking
// depends on fbdc_pkg, fbdc_front, fbdc_queue, fbdc_back
//
// channel  direction  handshake                  content
// s_*      in         s_tvalid / s_tready        pixel write, flush or fade command
// m_*      out        m_tvalid / m_tready        status and dirty column range
// cfg_*    in         cfg_valid / cfg_ready      clip register writes
//
// after reset the frame store is cleared one word a cycle, with s_tready low
// dropped writes pass the back end in pop and result handoff, stored writes in pop, read,
// compare and write, and result handoff
// flush walks the dirty map one dirty bit a cycle
// fade reads, scales and writes each pixel of the clip rectangle in the single frame store
// a two-beat command queue decouples input acceptance from back end stalls
`default_nettype none
module framebuffer_writer_dirty_columns_top #(
	parameter int WIDTH  = 240,
	parameter int HEIGHT = 240
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_tvalid,
	output logic             s_tready,
	// pos_x[11:0], pos_y[23:12], pixel_value[39:24], red[47:40], green[55:48],
	// blue[63:56], fade_percent[70:64], zero pad
	input  wire logic [fbdc_pkg::IN_DATA_W-1:0] s_tdata,
	// operation[1:0]
	input  wire logic [1:0]  s_tuser,
	output logic             m_tvalid,
	input  wire logic        m_tready,
	// range_start[7:0], range_end[15:8]
	output logic [fbdc_pkg::OUT_DATA_W-1:0] m_tdata,
	// status[2:0]
	output logic [2:0]       m_tuser,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [1:0]  cfg_index,
	input  wire logic [7:0]  cfg_data
);
	fbdc_pkg::cmd_t  front_cmd, head_cmd;
	fbdc_pkg::clip_t clip;
	logic q_full, q_not_empty, q_pop, clearing, push;

	assign cfg_ready = 1'b1;
	assign s_tready  = !q_full && !clearing;
	assign push      = s_tvalid && s_tready;

	fbdc_front #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_front (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tdata(s_tdata), .s_tuser(s_tuser),
		.cmd(front_cmd), .clip(clip)
	);

	fbdc_queue u_queue (
		.clk(clk), .arst_n(arst_n),
		.push(push), .push_cmd(front_cmd), .full(q_full),
		.pop(q_pop), .not_empty(q_not_empty), .head(head_cmd)
	);

	fbdc_back #(.WIDTH(WIDTH), .HEIGHT(HEIGHT)) u_back (
		.clk(clk), .arst_n(arst_n),
		.q_valid(q_not_empty), .q_cmd(head_cmd), .q_pop(q_pop),
		.clip(clip), .clearing(clearing),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser)
	);
endmodule
`default_nettype wire

@@ sv/fbdc_checker.sv @@
// fbdc_checker: port level checks of the frame buffer writer, bound to the top level
// depends on fbdc_pkg, framebuffer_writer_dirty_columns_top
`default_nettype none
module fbdc_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        m_tvalid,
	input wire logic        m_tready,
	input wire logic [15:0] m_tdata,
	input wire logic [2:0]  m_tuser
);
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
		else $error("output beat changed while stalled");

	a_range_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser != fbdc_pkg::ST_FLUSH_RANGE |-> m_tdata == 16'd0)
		else $error("range nonzero outside flush range");

	a_range_order: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser == fbdc_pkg::ST_FLUSH_RANGE |-> m_tdata[7:0] < m_tdata[15:8])
		else $error("flush range empty or inverted");
endmodule

bind framebuffer_writer_dirty_columns_top fbdc_checker u_fbdc_checker (
	.clk(clk), .arst_n(arst_n), .m_tvalid(m_tvalid), .m_tready(m_tready),
	.m_tdata(m_tdata), .m_tuser(m_tuser)
);
`default_nettype wire
